### design/pisou_pkg.sv
// Package for the permuted interface send order unit.
// Shared field widths and the control structs passed between submodules.
// No dependencies.
package pisou_pkg;

    localparam int TAG_W = 16;   // message tag width
    localparam int IDX_W = 3;    // interface index width, also one rank digit
    localparam int CFG_W = 4;    // iface_count register width

    // Rank digit counter control
    typedef struct packed {
        logic clear;   // zero every digit
        logic step;    // advance the rank by one, wrapping at n!
    } rank_ctl_t;

    // Order register file control
    typedef struct packed {
        logic init;    // load the identity order
        logic swap;    // apply one decode swap step
    } order_ctl_t;

endpackage

### design/pisou_req_if.sv
// Request channel interface: valid/ready handshake plus message tag.
// Depends on pisou_pkg.
interface pisou_req_if;

    logic                         valid;
    logic                         ready;
    logic [pisou_pkg::TAG_W-1:0]  message_tag;

    modport source (output valid, output message_tag, input ready);
    modport sink   (input valid, input message_tag, output ready);

endinterface

### design/pisou_res_if.sv
// Result channel interface: valid/ready handshake plus one ordered interface.
// Depends on pisou_pkg.
interface pisou_res_if;

    logic                         valid;
    logic                         ready;
    logic [pisou_pkg::TAG_W-1:0]  tag_out;
    logic [pisou_pkg::IDX_W-1:0]  iface_index;
    logic                         last_of_run;

    modport source (output valid, output tag_out, output iface_index, output last_of_run,
                    input ready);
    modport sink   (input valid, input tag_out, input iface_index, input last_of_run,
                    output ready);

endinterface

### design/pisou_rank_ctr.sv
// Permutation rank held as mixed-radix (factoradic) digits, one per radix.
// Depends on pisou_pkg.
module pisou_rank_ctr #(
    parameter int MAX_IFACES = 8,
    localparam int AW = (MAX_IFACES > 1) ? $clog2(MAX_IFACES) : 1,
    localparam int CW = $clog2(MAX_IFACES + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pisou_pkg::rank_ctl_t        ctl,
    input  logic [CW-1:0]               n,
    input  logic [AW-1:0]               sel,
    output logic [pisou_pkg::IDX_W-1:0] digit
);
    import pisou_pkg::*;

    // Entry r holds the digit of radix r+1; entry 0 stays zero.
    logic [IDX_W-1:0] d_reg  [MAX_IFACES];
    logic [IDX_W-1:0] d_next [MAX_IFACES];
    logic             carry;

    always_comb
    begin
        d_next = d_reg;
        carry  = 1'b1;
        if (ctl.clear)
        begin
            for (int r = 0; r < MAX_IFACES; r++)
                d_next[r] = '0;
        end
        else if (ctl.step)
        begin
            // ripple the increment through the active digits
            for (int r = 1; r < MAX_IFACES; r++)
            begin
                if ((CW'(r) < n) && carry)
                begin
                    if (d_reg[r] == IDX_W'(r))
                        d_next[r] = '0;
                    else
                    begin
                        d_next[r] = d_reg[r] + 1'b1;
                        carry     = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_IFACES; r++)
                d_reg[r] <= '0;
        end
        else
            d_reg <= d_next;
    end

    assign digit = d_reg[sel];

endmodule

### design/pisou_order_regs.sv
// Interface order register file with one shared read port and the swap step.
// Depends on pisou_pkg.
module pisou_order_regs #(
    parameter int MAX_IFACES = 8,
    localparam int AW = (MAX_IFACES > 1) ? $clog2(MAX_IFACES) : 1
) (
    input  logic                        clk,
    input  pisou_pkg::order_ctl_t       ctl,
    input  logic [AW-1:0]               swap_pos,
    input  logic [AW-1:0]               top_pos,
    input  logic [AW-1:0]               rd_addr,
    output logic [pisou_pkg::IDX_W-1:0] rd_data
);
    import pisou_pkg::*;

    logic [IDX_W-1:0] a_reg  [MAX_IFACES];
    logic [IDX_W-1:0] a_next [MAX_IFACES];

    assign rd_data = a_reg[rd_addr];

    // The top slot of each step is still untouched, so it holds its own index:
    // swapping only needs the entry at swap_pos, which the read port supplies.
    always_comb
    begin
        a_next = a_reg;
        if (ctl.init)
        begin
            for (int i = 0; i < MAX_IFACES; i++)
                a_next[i] = IDX_W'(i);
        end
        else if (ctl.swap)
        begin
            for (int i = 0; i < MAX_IFACES; i++)
            begin
                if (AW'(i) == swap_pos)
                    a_next[i] = IDX_W'(top_pos);
                else if (AW'(i) == top_pos)
                    a_next[i] = rd_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
    end

endmodule

### design/permuted_interface_send_order_unit.sv
// Permuted interface send order unit: accept a request, decode the current
// permutation rank with one swap per cycle, then stream n ordered interfaces.
// Sequence: accept, then one swap step per radix from 2 to n, then results are loaded into
// the output register one per cycle while res.ready is high; a new request is taken only
// after the last transfer of the run. With n = 0 the request is dropped and the block stays idle.
// Reset: rst_n clears iface_count and the rank to zero and leaves the block idle.
module permuted_interface_send_order_unit #(
    parameter int MAX_IFACES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pisou_pkg::CFG_W-1:0] cfg_wdata,
    pisou_req_if.sink                   req,
    pisou_res_if.source                 res
);
    import pisou_pkg::*;

    localparam int AW = (MAX_IFACES > 1) ? $clog2(MAX_IFACES) : 1;
    localparam int CW = $clog2(MAX_IFACES + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SWAP = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] cfg_reg;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    j_reg, j_next;      // radix of the current swap step
    logic [CW-1:0]    i_reg, i_next;      // next position to emit
    logic [TAG_W-1:0] tag_reg;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_last_reg;

    logic             req_xfer;
    logic             res_xfer;
    logic             load_out;
    logic [CW-1:0]    n_sat;
    logic [CW-1:0]    jm1;
    logic [IDX_W-1:0] digit;
    logic [IDX_W-1:0] rd_data;
    logic [AW-1:0]    rd_addr;
    rank_ctl_t        rank_ctl;
    order_ctl_t       order_ctl;

    // Saturate the configured count at the number of interfaces built in.
    assign n_sat = (cfg_reg > CFG_W'(MAX_IFACES)) ? CW'(MAX_IFACES) : CW'(cfg_reg);

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign res_xfer  = res.valid && res.ready;

    assign jm1 = j_reg - 1'b1;

    // Refill the output register when it is empty or being drained,
    // but not once the last result of the run is sitting in it.
    assign load_out = (state_reg == ST_EMIT) && (!out_valid_reg || res.ready)
                      && !(out_valid_reg && out_last_reg);

    // Shared read port: the swap digit's slot while decoding, else the emit position.
    assign rd_addr = (state_reg == ST_SWAP) ? AW'(digit) : AW'(i_reg);

    // A config write restarts the rank; the last transfer of a run advances it.
    assign rank_ctl.clear = cfg_we;
    assign rank_ctl.step  = res_xfer && out_last_reg;

    assign order_ctl.init = req_xfer;
    assign order_ctl.swap = (state_reg == ST_SWAP);

    pisou_rank_ctr #(
        .MAX_IFACES (MAX_IFACES)
    ) u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rank_ctl),
        .n     (n_reg),
        .sel   (AW'(jm1)),
        .digit (digit)
    );

    pisou_order_regs #(
        .MAX_IFACES (MAX_IFACES)
    ) u_order (
        .clk      (clk),
        .ctl      (order_ctl),
        .swap_pos (AW'(digit)),
        .top_pos  (AW'(jm1)),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        i_next         = i_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    n_next = n_sat;
                    j_next = CW'(2);
                    i_next = '0;
                    // no interfaces: drop the request, nothing to emit
                    if (n_sat >= CW'(2))
                        state_next = ST_SWAP;
                    else if (n_sat == CW'(1))
                        state_next = ST_EMIT;
                end
            end
            ST_SWAP:
            begin
                // advance one radix per cycle until the top one is done
                if (j_reg == n_reg)
                    state_next = ST_EMIT;
                else
                    j_next = j_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    i_next         = i_reg + 1'b1;
                end
                else if (res_xfer)
                begin
                    // the last transfer of the run has gone out
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= '0;
            n_reg         <= '0;
            j_reg         <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            if (load_out)
                out_last_reg <= (i_reg == n_reg - 1'b1);
            else if (res_xfer)
                out_last_reg <= 1'b0;
        end
    end

    // Payload registers: hold the tag for the whole run, load each index on refill.
    always_ff @(posedge clk)
    begin
        if (req_xfer)
            tag_reg <= req.message_tag;
        if (load_out)
            out_idx_reg <= rd_data;
    end

    assign res.valid       = out_valid_reg;
    assign res.tag_out     = tag_reg;
    assign res.iface_index = out_idx_reg;
    assign res.last_of_run = out_last_reg;

    // One request at a time: never take a request while a result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !req.ready)
        else $error("request accepted while a result is pending");

    // Every swap step stays within the active radix range.
    a_swap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAP) |-> (j_reg >= CW'(2)) && (j_reg <= n_reg))
        else $error("swap step outside the active radix range");

    // Emitted interfaces are always among the active ones.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (CW'(res.iface_index) < n_reg))
        else $error("emitted interface outside the active set");

    // The run ends with its last transfer and the block returns to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_xfer && res.last_of_run) |=> (state_reg == ST_IDLE) && !res.valid)
        else $error("block did not return to idle after the last transfer");

endmodule
